[rtl/glyph_text_page_renderer_unit_assert.svh]
// Assertion macros for the checker of the text page renderer.
`ifndef GLYPH_TEXT_PAGE_RENDERER_UNIT_ASSERT_SVH
`define GLYPH_TEXT_PAGE_RENDERER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define GTPR_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define GTPR_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[rtl/gtpr_pkg.sv]
`timescale 1ns / 1ps

package gtpr_pkg;

    // Page geometry.
    localparam int PAGE_SIZE = 60;
    localparam int ADDR_W    = $clog2(PAGE_SIZE);
    // Wide enough for a page row plus the glyph height, and for PAGE_SIZE itself.
    localparam int ROW_W     = 8;
    // Signed width of the start column arithmetic; covers every input pattern.
    localparam int SW        = 11;

    // Character codes.
    localparam logic [7:0] DOT_CODE     = 8'd46;
    localparam logic [7:0] SPACE_CODE   = 8'd32;
    localparam logic [7:0] STAR_CODE    = 8'd42;
    localparam logic [7:0] FIRST_LETTER = 8'd65;
    localparam logic [7:0] LAST_LETTER  = 8'd90;

    // Glyph geometry.
    localparam int LETTERS     = 26;
    localparam int GLYPH_ROWS  = 5;
    localparam int GLYPH_COLS  = 5;

    // Command codes.
    localparam logic [1:0] CMD_DRAW  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Alignment codes.
    localparam logic [1:0] ALIGN_COL    = 2'd0;
    localparam logic [1:0] ALIGN_LEFT   = 2'd1;
    localparam logic [1:0] ALIGN_RIGHT  = 2'd2;
    localparam logic [1:0] ALIGN_CENTRE = 2'd3;

    // Glyph rows for the letters; bit 4 is the leftmost column.
    localparam logic [4:0] GLYPH_ROM [LETTERS][GLYPH_ROWS] = '{
        '{5'h0E, 5'h11, 5'h1F, 5'h11, 5'h11}, '{5'h1E, 5'h11, 5'h1E, 5'h11, 5'h1E},
        '{5'h0F, 5'h10, 5'h10, 5'h10, 5'h0F}, '{5'h1E, 5'h11, 5'h11, 5'h11, 5'h1E},
        '{5'h1F, 5'h10, 5'h1C, 5'h10, 5'h1F}, '{5'h1F, 5'h10, 5'h1C, 5'h10, 5'h10},
        '{5'h0F, 5'h10, 5'h13, 5'h11, 5'h0E}, '{5'h11, 5'h11, 5'h1F, 5'h11, 5'h11},
        '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h1F}, '{5'h07, 5'h02, 5'h02, 5'h12, 5'h0C},
        '{5'h11, 5'h12, 5'h1C, 5'h12, 5'h11}, '{5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
        '{5'h11, 5'h1B, 5'h15, 5'h11, 5'h11}, '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11},
        '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E}, '{5'h1E, 5'h11, 5'h1E, 5'h10, 5'h10},
        '{5'h0E, 5'h11, 5'h11, 5'h13, 5'h0F}, '{5'h1E, 5'h11, 5'h1E, 5'h12, 5'h11},
        '{5'h0F, 5'h10, 5'h0E, 5'h01, 5'h1E}, '{5'h1F, 5'h15, 5'h04, 5'h04, 5'h0E},
        '{5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}, '{5'h11, 5'h11, 5'h0A, 5'h0A, 5'h04},
        '{5'h11, 5'h11, 5'h15, 5'h1B, 5'h11}, '{5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11},
        '{5'h11, 5'h0A, 5'h04, 5'h04, 5'h04}, '{5'h1F, 5'h02, 5'h04, 5'h08, 5'h1F}
    };

    // Request to the start column unit.
    typedef struct packed {
        logic       large_font;
        logic [1:0] align;
        logic [5:0] column;
        logic [5:0] text_length;
        logic [5:0] char_index;
    } t_calc_req;

    // One row write: cells under the mask take the code.
    typedef struct packed {
        logic                 en;
        logic [ADDR_W-1:0]    addr;
        logic [PAGE_SIZE-1:0] mask;
        logic [7:0]           code;
    } t_wr_req;

    // One row read, data appears on the following cycle.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd_req;

    function automatic logic is_letter(input logic [7:0] code);
        return (code >= FIRST_LETTER) && (code <= LAST_LETTER);
    endfunction

    // Glyph row bits, zero for codes that are not letters.
    function automatic logic [4:0] glyph_row(input logic [7:0] code,
                                             input logic [2:0] grow);
        logic [7:0] li;
        li = code - FIRST_LETTER;
        if (is_letter(code) && (grow < 3'(GLYPH_ROWS))) begin
            return GLYPH_ROM[li[4:0]][grow];
        end
        return 5'd0;
    endfunction

endpackage

[rtl/gtpr_start_calc.sv]
`timescale 1ns / 1ps

module gtpr_start_calc (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  gtpr_pkg::t_calc_req         i_req,
    output logic                        o_done,
    output logic signed [gtpr_pkg::SW-1:0] o_start
);
    import gtpr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LW,
        ST_BASE,
        ST_IW,
        ST_SUM
    } t_state;

    t_state                r_state;
    t_calc_req             r_req;
    logic signed [SW-1:0]  r_acc;
    logic signed [SW-1:0]  r_tmp;
    logic                  r_done;

    logic signed [SW-1:0]  op_a;
    logic signed [SW-1:0]  op_b;
    logic                  op_sub;
    logic signed [SW-1:0]  l_ext;
    logic signed [SW-1:0]  x_ext;
    logic signed [SW-1:0]  sum;

    assign l_ext = SW'(r_req.text_length);
    assign x_ext = SW'(r_req.char_index);

    // Operand selection for the one shared adder, one step per state.
    always_comb begin
        op_a   = '0;
        op_b   = '0;
        op_sub = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
            end
            ST_LW: begin
                // Text width: L or 4L + 2L.
                op_a = r_req.large_font ? (l_ext <<< 2) : l_ext;
                op_b = r_req.large_font ? (l_ext <<< 1) : '0;
            end
            ST_BASE: begin
                unique case (r_req.align)
                    ALIGN_COL: begin
                        op_a = SW'(r_req.column);
                    end
                    ALIGN_LEFT: begin
                        op_a = SW'(1);
                    end
                    ALIGN_RIGHT: begin
                        op_a   = SW'(PAGE_SIZE + 1);
                        op_b   = r_acc;
                        op_sub = 1'b1;
                    end
                    ALIGN_CENTRE: begin
                        // The width is never negative, so the shift truncates.
                        op_a   = SW'(PAGE_SIZE / 2 + 1);
                        op_b   = r_acc >>> 1;
                        op_sub = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            ST_IW: begin
                // Offset of this character: index times the pitch.
                op_a = r_req.large_font ? (x_ext <<< 2) : x_ext;
                op_b = r_req.large_font ? (x_ext <<< 1) : '0;
            end
            ST_SUM: begin
                op_a = r_acc;
                op_b = r_tmp;
            end
            default: begin
            end
        endcase
    end

    assign sum = op_a + (op_sub ? ~op_b : op_b) + SW'(op_sub);

    // Step sequencer and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_req   <= i_req;
                        r_state <= ST_LW;
                    end
                end
                ST_LW: begin
                    r_acc   <= sum;
                    r_state <= ST_BASE;
                end
                ST_BASE: begin
                    r_acc   <= sum;
                    r_state <= ST_IW;
                end
                ST_IW: begin
                    r_tmp   <= sum;
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_acc   <= sum;
                    r_done  <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_start = r_acc;

endmodule

[rtl/gtpr_page_store.sv]
`timescale 1ns / 1ps

module gtpr_page_store (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_clear,
    input  gtpr_pkg::t_wr_req                       i_wr,
    input  gtpr_pkg::t_rd_req                       i_rd,
    output logic [gtpr_pkg::PAGE_SIZE-1:0][7:0]     o_rd_row
);
    import gtpr_pkg::*;

    // One memory word per page row.
    logic [PAGE_SIZE-1:0][7:0] mem [PAGE_SIZE];
    logic [PAGE_SIZE-1:0]      r_row_ok;
    logic [PAGE_SIZE-1:0][7:0] r_rd_row;
    logic                      r_rd_ok;
    logic                      wr_fresh;

    // A row never written since the last clear holds dots everywhere.
    assign wr_fresh = !r_row_ok[i_wr.addr];

    // Row valid flags, cleared at once by reset or a clear command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ok <= '0;
        end else if (i_clear) begin
            r_row_ok <= '0;
        end else if (i_wr.en) begin
            r_row_ok[i_wr.addr] <= 1'b1;
        end
    end

    // Cell-enabled row write; a fresh row gets dots in the unmasked cells.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            for (int k = 0; k < PAGE_SIZE; k++) begin
                if (i_wr.mask[k] || wr_fresh) begin
                    mem[i_wr.addr][k] <= i_wr.mask[k] ? i_wr.code : DOT_CODE;
                end
            end
        end
    end

    // Registered row read.
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_row <= mem[i_rd.addr];
            r_rd_ok  <= r_row_ok[i_rd.addr];
        end
    end

    assign o_rd_row = r_rd_ok ? r_rd_row : {PAGE_SIZE{DOT_CODE}};

endmodule

[rtl/glyph_text_page_renderer_unit.sv]
`timescale 1ns / 1ps
// Draw: after the accept cycle the start column unit runs its width, base, offset and sum
// steps on its shared adder and the main sequencer takes its done flag; then one row write
// per cycle (1 small, 5 glyph), none for a glyph code outside the letters. Read: the row is
// fetched in the accept cycle, then 60 words follow, one per cycle unless stalled. Input stall
// stays high meanwhile. Reset (synchronous, active low) idles the sequencers and clears the
// row valid flags, so the whole page reads as dots at once with no clearing pass.
module glyph_text_page_renderer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_command,
    input  logic       i_large_font,
    input  logic [1:0] i_align,
    input  logic [5:0] i_row,
    input  logic [5:0] i_column,
    input  logic [5:0] i_text_length,
    input  logic [5:0] i_char_index,
    input  logic [7:0] i_char_code,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_cell_res,
    output logic [5:0] o_cell_column,
    output logic       o_last
);
    import gtpr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_DRAW,
        S_READ
    } t_state;

    t_state                r_state;
    logic [5:0]            r_row;
    logic                  r_large;
    logic [7:0]            r_code;
    logic [2:0]            r_gi;
    logic [ADDR_W-1:0]     r_cidx;

    logic                  in_acc;
    logic                  out_acc;
    logic                  read_ok;
    logic                  calc_start;
    logic                  calc_done;
    logic signed [SW-1:0]  start_col;
    t_calc_req             calc_req;
    t_wr_req               wr;
    t_rd_req               rd;
    logic                  clear;
    logic [PAGE_SIZE-1:0][7:0] rd_row;
    logic [ROW_W-1:0]      draw_row;
    logic                  row_in_page;
    logic [4:0]            glyph_bits;
    logic [PAGE_SIZE-1:0]  col_mask;
    logic signed [SW-1:0]  j;
    logic                  draw_last;
    logic [ADDR_W:0]       col_num;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;
    assign o_stall = (r_state != S_IDLE);

    // Start column unit.
    assign calc_start = in_acc && (i_command == CMD_DRAW);
    assign calc_req   = '{large_font:  i_large_font,
                          align:       i_align,
                          column:      i_column,
                          text_length: i_text_length,
                          char_index:  i_char_index};

    gtpr_start_calc u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (calc_start),
        .i_req   (calc_req),
        .o_done  (calc_done),
        .o_start (start_col)
    );

    // Read address comes straight from the word so the row is ready next cycle.
    assign read_ok = (i_row != 6'd0) && ({2'b00, i_row} <= ROW_W'(PAGE_SIZE));
    assign rd.en   = in_acc && (i_command == CMD_READ) && read_ok;
    assign rd.addr = ADDR_W'({2'b00, i_row} - ROW_W'(1));
    assign clear   = in_acc && (i_command == CMD_CLEAR);

    // Page row touched in this draw cycle, and its clipping.
    assign draw_row    = {2'b00, r_row} + ROW_W'(r_gi);
    assign row_in_page = (draw_row != '0) && (draw_row <= ROW_W'(PAGE_SIZE));
    assign glyph_bits  = glyph_row(r_code, r_gi);

    // Per-column hit against the start column; columns off the page never appear.
    always_comb begin
        j        = '0;
        col_mask = '0;
        for (int k = 0; k < PAGE_SIZE; k++) begin
            j = SW'(k + 1) - start_col;
            if (r_large) begin
                if ((j >= 0) && (j < SW'(GLYPH_COLS))) begin
                    col_mask[k] = glyph_bits[3'(GLYPH_COLS - 1) - j[2:0]];
                end
            end else begin
                col_mask[k] = (j == '0);
            end
        end
    end

    assign wr.en   = (r_state == S_DRAW) && row_in_page &&
                     (r_large || (r_code != SPACE_CODE));
    assign wr.addr = ADDR_W'(draw_row - ROW_W'(1));
    assign wr.mask = col_mask;
    assign wr.code = r_large ? STAR_CODE : r_code;

    gtpr_page_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (clear),
        .i_wr     (wr),
        .i_rd     (rd),
        .o_rd_row (rd_row)
    );

    assign draw_last = !r_large || (r_gi == 3'(GLYPH_ROWS - 1));

    // Main sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_row   <= i_row;
                        r_large <= i_large_font;
                        r_code  <= i_char_code;
                        r_gi    <= '0;
                        r_cidx  <= '0;
                        if (calc_start) begin
                            r_state <= S_CALC;
                        end else if (rd.en) begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_CALC: begin
                    if (calc_done) begin
                        // Codes outside the letters draw nothing in the glyph font.
                        r_state <= (r_large && !is_letter(r_code)) ? S_IDLE : S_DRAW;
                    end
                end
                S_DRAW: begin
                    if (draw_last) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_gi <= r_gi + 3'd1;
                    end
                end
                S_READ: begin
                    if (out_acc) begin
                        if (o_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_cidx <= r_cidx + ADDR_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result word, driven only from registers.
    assign col_num       = {1'b0, r_cidx} + (ADDR_W + 1)'(1);
    assign o_valid       = (r_state == S_READ);
    assign o_cell_res    = rd_row[r_cidx];
    assign o_cell_column = 6'(col_num);
    assign o_last        = (r_cidx == ADDR_W'(PAGE_SIZE - 1));

endmodule

[rtl/gtpr_checker.sv]
`timescale 1ns / 1ps
`include "glyph_text_page_renderer_unit_assert.svh"

module gtpr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_cell_res,
    input logic [5:0] o_cell_column,
    input logic       o_last
);
    import gtpr_pkg::*;

    // The block takes no new word while a row is streaming.
    `GTPR_ASSERT_NOW(a_busy_on_out, o_valid, o_stall, "input open during row stream")

    // A row keeps streaming until its final cell is taken.
    `GTPR_ASSERT_NXT(a_row_runs, o_valid && !i_stall && !o_last, o_valid, "row stream broke off")

    // Columns of a row come in order, one apart.
    `GTPR_ASSERT_NXT(a_col_step, o_valid && !i_stall && !o_last,
                     o_cell_column == ($past(o_cell_column) + 6'd1), "column out of order")

    // The final cell sits in the last page column.
    `GTPR_ASSERT_NOW(a_last_col, o_valid && o_last, o_cell_column == 6'(PAGE_SIZE),
                     "last flag on wrong column")

    // A stalled word holds still.
    `GTPR_ASSERT_NXT(a_hold, o_valid && i_stall, o_valid && $stable(o_cell_res),
                     "stalled word changed")

endmodule

bind glyph_text_page_renderer_unit gtpr_checker u_gtpr_checker (.*);
